// ===== rtl/crc16fc_pkg.sv =====
package crc16fc_pkg;

  typedef logic [7:0]  byte_t;
  typedef logic [5:0]  len_t;
  typedef logic [15:0] crc_t;

  // receive buffer size, the payload limit never exceeds it minus the overhead bytes
  localparam int unsigned BufBytes  = 64;
  localparam int unsigned LenOffset = 3;
  localparam int unsigned LenCap    = BufBytes - LenOffset;

  localparam crc_t  CrcPoly      = 16'h8005;
  localparam byte_t DevTxErrByte = 8'hFF;
  localparam byte_t WakeupByte   = 8'h11;
  localparam len_t  MaxLenReset  = 6'd36;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_BAD_LEN   = 3'd1,
    ST_CRC_BAD   = 3'd2,
    ST_DEV_TXERR = 3'd3,
    ST_WAKEUP    = 3'd4
  } status_e;

endpackage

// ===== rtl/crc16_response_frame_checker.sv =====
// a received byte passes through the input register and then the result register
// throughput: one byte per cycle; while a result waits one more byte is taken
//   into the input register, then the input stalls until the result drains
// reset: asynchronous active low, expects a count byte, crc cleared, limit 36
module crc16_response_frame_checker (
  input  logic                clk_i,
  input  logic                rst_ni,
  // configuration write channel
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  crc16fc_pkg::len_t   cfg_max_payload_len_i,
  // received byte channel
  input  logic                rx_valid_i,
  output logic                rx_ready_o,
  input  crc16fc_pkg::byte_t  rx_byte_i,
  // result channel
  output logic                res_valid_o,
  input  logic                res_ready_i,
  output logic                is_status_o,
  output crc16fc_pkg::byte_t  payload_byte_o,
  output logic [2:0]          frame_status_o,
  output crc16fc_pkg::len_t   payload_len_o
);
  import crc16fc_pkg::*;

  typedef enum logic [1:0] {
    PH_COUNT   = 2'd0,
    PH_PAYLOAD = 2'd1,
    PH_CRC_LO  = 2'd2,
    PH_CRC_HI  = 2'd3
  } phase_e;

  // configuration
  len_t   max_len_q;

  // input register
  logic   in_valid_q;
  byte_t  in_byte_q;

  // frame state
  phase_e phase_q,   phase_d;
  len_t   left_q,    left_d;
  crc_t   crc_q,     crc_d;
  len_t   flen_q,    flen_d;
  byte_t  first_q,   first_d;
  byte_t  crc_lo_q,  crc_lo_d;

  // result register
  logic    res_valid_q;
  logic    res_stat_q,  res_stat_d;
  byte_t   res_byte_q,  res_byte_d;
  status_e res_fs_q,    res_fs_d;
  len_t    res_len_q,   res_len_d;
  logic    has_res;

  logic   advance;
  logic   work;
  byte_t  len8;
  byte_t  limit8;
  logic   len_ok;
  crc_t   crc_seed;
  crc_t   crc_next;

  // the result register can take a new value when empty or being drained
  assign advance     = !res_valid_q || res_ready_i;
  // the byte in the input register is processed this cycle
  assign work        = in_valid_q && advance;
  assign rx_ready_o  = !in_valid_q || advance;
  assign cfg_ready_o = 1'b1;

  // configuration register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_len_q <= MaxLenReset;
    end else if (cfg_valid_i) begin
      max_len_q <= cfg_max_payload_len_i;
    end
  end

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (rx_ready_o) begin
      in_valid_q <= rx_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rx_valid_i && rx_ready_o) begin
      in_byte_q <= rx_byte_i;
    end
  end

  // length check on the count byte, limit clipped to the buffer size minus the overhead bytes
  assign len8   = in_byte_q - 8'(LenOffset);
  assign limit8 = ({2'b00, max_len_q} > 8'(LenCap)) ? 8'(LenCap) : {2'b00, max_len_q};
  assign len_ok = (len8 != 8'd0) && (len8 <= limit8);

  // a new frame starts the crc from zero
  assign crc_seed = (phase_q == PH_COUNT) ? '0 : crc_q;

  crc16fc_crc_step u_crc_step (
    .crc_i  (crc_seed),
    .byte_i (in_byte_q),
    .crc_o  (crc_next)
  );

  always_comb begin
    phase_d    = phase_q;
    left_d     = left_q;
    crc_d      = crc_q;
    flen_d     = flen_q;
    first_d    = first_q;
    crc_lo_d   = crc_lo_q;
    has_res    = 1'b0;
    res_stat_d = 1'b0;
    res_byte_d = '0;
    res_fs_d   = ST_OK;
    res_len_d  = '0;
    unique case (phase_q)
      PH_COUNT: begin
        if (!len_ok) begin
          // reject at once, next byte is a count byte again
          crc_d      = '0;
          has_res    = 1'b1;
          res_stat_d = 1'b1;
          res_fs_d   = ST_BAD_LEN;
        end else begin
          crc_d   = crc_next;
          flen_d  = len8[5:0];
          left_d  = len8[5:0];
          phase_d = PH_PAYLOAD;
        end
      end
      PH_PAYLOAD: begin
        if (left_q == flen_q) begin
          first_d = in_byte_q;
        end
        crc_d      = crc_next;
        left_d     = left_q - 6'd1;
        if (left_q == 6'd1) begin
          phase_d = PH_CRC_LO;
        end
        has_res    = 1'b1;
        res_byte_d = in_byte_q;
      end
      PH_CRC_LO: begin
        crc_lo_d = in_byte_q;
        phase_d  = PH_CRC_HI;
      end
      PH_CRC_HI: begin
        // mismatch wins over the single-byte device codes
        has_res    = 1'b1;
        res_stat_d = 1'b1;
        res_len_d  = flen_q;
        priority if ({in_byte_q, crc_lo_q} != crc_q) begin
          res_fs_d = ST_CRC_BAD;
        end else if (flen_q == 6'd1 && first_q == DevTxErrByte) begin
          res_fs_d = ST_DEV_TXERR;
        end else if (flen_q == 6'd1 && first_q == WakeupByte) begin
          res_fs_d = ST_WAKEUP;
        end else begin
          res_fs_d = ST_OK;
        end
        phase_d = PH_COUNT;
        crc_d   = '0;
        left_d  = '0;
      end
      default: begin
        phase_d = PH_COUNT;
      end
    endcase
  end

  // frame state, updated once per processed byte
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_COUNT;
      left_q   <= '0;
      crc_q    <= '0;
      flen_q   <= '0;
      first_q  <= '0;
      crc_lo_q <= '0;
    end else if (work) begin
      phase_q  <= phase_d;
      left_q   <= left_d;
      crc_q    <= crc_d;
      flen_q   <= flen_d;
      first_q  <= first_d;
      crc_lo_q <= crc_lo_d;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else if (advance) begin
      res_valid_q <= work && has_res;
    end
  end

  always_ff @(posedge clk_i) begin
    if (work && has_res) begin
      res_stat_q <= res_stat_d;
      res_byte_q <= res_byte_d;
      res_fs_q   <= res_fs_d;
      res_len_q  <= res_len_d;
    end
  end

  assign res_valid_o    = res_valid_q;
  assign is_status_o    = res_stat_q;
  assign payload_byte_o = res_byte_q;
  assign frame_status_o = res_fs_q;
  assign payload_len_o  = res_len_q;

  // a stalled input byte only happens behind a blocked result
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !rx_ready_o |-> (in_valid_q && res_valid_q && !res_ready_i))
    else $error("input stalled without a blocked result");

  // payload phase always has bytes outstanding
  a_left_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_PAYLOAD) |-> (left_q != 6'd0 && left_q <= flen_q))
    else $error("payload counter out of range");

  // accepted frame length never exceeds the clipped limit
  a_flen_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q != PH_COUNT) |-> (flen_q != 6'd0 && 8'(flen_q) <= 8'(LenCap)))
    else $error("frame length beyond buffer");

  // payload results and bad length results carry no length
  a_res_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_q && (!res_stat_q || res_fs_q == ST_BAD_LEN)) |-> (res_len_q == 6'd0))
    else $error("unexpected length in result");

  // a processed crc high byte always closes the frame
  a_frame_close: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (work && phase_q == PH_CRC_HI) |=> (phase_q == PH_COUNT && res_valid_q && res_stat_q))
    else $error("frame not closed after crc");

endmodule

// ===== rtl/crc16fc_crc_step.sv =====
module crc16fc_crc_step (
  input  crc16fc_pkg::crc_t  crc_i,
  input  crc16fc_pkg::byte_t byte_i,
  output crc16fc_pkg::crc_t  crc_o
);
  import crc16fc_pkg::*;

  // eight bit steps, data lsb first, unrolled into xor logic
  always_comb begin
    crc_t c;
    c = crc_i;
    for (int i = 0; i < 8; i++) begin
      if (byte_i[i] ^ c[15]) begin
        c = {c[14:0], 1'b0} ^ CrcPoly;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    crc_o = c;
  end

endmodule
